// ===== design/bspu_pkg.sv =====
package bspu_pkg;

  localparam int PosW        = 15;
  localparam int CountW      = 7;
  localparam int ValueW      = 64;
  localparam int StreamAddrW = PosW - 3 + 1;  // byte address of the last byte touched
  localparam int FrameW      = ValueW + 8;    // up to nine bytes of one access
  localparam int SpanW       = 4;             // byte index within an access, 0..8

  localparam logic [CountW-1:0] MaxCount   = CountW'(ValueW);
  localparam logic [SpanW-1:0]  MaxByteIdx = SpanW'(FrameW / 8 - 1);
  localparam logic [7:0]        ByteMask   = 8'hFF;
  localparam logic [2:0]        OffMask    = 3'h7;

  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_RDLAST,
    ST_WR,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wr_data;
  } store_req_t;

endpackage

// ===== design/bspu_store.sv =====
module bspu_store #(
  parameter int STORE_BYTES = 4096,
  parameter int ADDR_W      = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bspu_pkg::store_req_t  req_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output logic [7:0]            rd_data_o
);

  localparam int IdxW = $clog2(STORE_BYTES);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rd_q;
  logic       rd_ok_q;
  logic       wr_hit;
  logic       rd_hit;

  // drop writes past the end, read them as zero
  assign wr_hit = req_i.wr_en && (32'(wr_addr_i) < 32'(STORE_BYTES));
  assign rd_hit = req_i.rd_en && (32'(rd_addr_i) < 32'(STORE_BYTES));

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_addr_i[IdxW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_hit) begin
      rd_q <= mem_q[rd_addr_i[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= rd_hit;
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : 8'h00;

endmodule

// ===== design/bit_stream_pack_unpack.sv =====
// Channel  | Ports                                             | Dir | Handshake
// request  | mode_i bit_position_i bit_count_i write_value_i   | in  | start && !busy
// result   | read_value_o                                      | out | done_o, one cycle
//
// A request touching k bytes (k = 1..9) keeps busy high while ST_RD reads its
// bytes and ST_RDLAST ends it, or while ST_WR writes them (ST_MERGE after, to merge
// a partly filled first byte); a zero-count request leaves busy low and gives
// done_o in the next cycle. The byte-wide ports of the store set the pace: one byte
// is read or written per cycle. After reset a clearing pass writes zero to every
// byte with busy high. The result strobe is not held off: the receiver takes it.
module bit_stream_pack_unpack #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [bspu_pkg::PosW-1:0]   bit_position_i,
  input  logic [bspu_pkg::CountW-1:0] bit_count_i,
  input  logic [bspu_pkg::ValueW-1:0] write_value_i,
  output logic                        done_o,
  output logic [bspu_pkg::ValueW-1:0] read_value_o
);

  localparam int IdxW = $clog2(STORE_BYTES);
  localparam int SAW  = (IdxW > bspu_pkg::StreamAddrW) ? IdxW : bspu_pkg::StreamAddrW;

  bspu_pkg::state_e state_q, state_d;

  logic [SAW-1:0]                  clr_q;
  logic [bspu_pkg::SpanW-1:0]      cnt_q;
  logic [bspu_pkg::SpanW-1:0]      last_q;
  logic [bspu_pkg::PosW-4:0]       addr0_q;
  logic [2:0]                      off_q;
  logic [2:0]                      tail_q;
  logic                            mode_q;
  logic [bspu_pkg::FrameW-1:0]     shf_q;
  logic [bspu_pkg::FrameW-1:0]     acc_q;
  logic                            rd_vld_q;
  logic                            rd_first_q;
  logic                            done_q;
  logic [bspu_pkg::ValueW-1:0]     result_q;

  logic                            accept;
  logic [bspu_pkg::CountW-1:0]     n_sat;
  logic [7:0]                      span_end;
  logic [bspu_pkg::ValueW-1:0]     vmask;
  logic [bspu_pkg::FrameW-1:0]     frame;
  logic [SAW-1:0]                  stream_addr;
  logic [7:0]                      rd_data;
  logic [7:0]                      rd_byte;
  logic [bspu_pkg::FrameW-1:0]     acc_next;
  logic [bspu_pkg::FrameW-1:0]     acc_align;
  bspu_pkg::store_req_t            store_req;
  logic [SAW-1:0]                  wr_addr;
  logic [SAW-1:0]                  rd_addr;

  assign busy   = (state_q != bspu_pkg::ST_IDLE);
  assign accept = start && !busy;

  // request decode
  assign n_sat    = (bit_count_i > bspu_pkg::MaxCount) ? bspu_pkg::MaxCount : bit_count_i;
  assign span_end = 8'(bit_position_i[2:0]) + 8'(n_sat) - 8'd1;

  always_comb begin
    for (int i = 0; i < bspu_pkg::ValueW; i++) begin
      vmask[i] = write_value_i[i] && (i < int'(n_sat));
    end
  end

  // place the value so that its last bit sits at its stream position in the last byte
  assign frame = bspu_pkg::FrameW'(vmask) << (~span_end[2:0]);

  assign stream_addr = SAW'(addr0_q) + SAW'(cnt_q);

  // read assembly: one byte per cycle, leading bits of the first byte dropped
  assign rd_byte   = rd_first_q ? (rd_data & (bspu_pkg::ByteMask >> off_q)) : rd_data;
  assign acc_next  = {acc_q[bspu_pkg::FrameW-9:0], rd_byte};
  assign acc_align = acc_next >> tail_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bspu_pkg::ST_CLEAR: begin
        if (clr_q == SAW'(STORE_BYTES - 1)) state_d = bspu_pkg::ST_IDLE;
      end
      bspu_pkg::ST_IDLE: begin
        if (accept && n_sat != '0) begin
          state_d = (mode_i == bspu_pkg::ModeWrite) ? bspu_pkg::ST_WR : bspu_pkg::ST_RD;
        end
      end
      bspu_pkg::ST_RD: begin
        if (cnt_q == last_q) state_d = bspu_pkg::ST_RDLAST;
      end
      bspu_pkg::ST_RDLAST: begin
        state_d = bspu_pkg::ST_IDLE;
      end
      bspu_pkg::ST_WR: begin
        if (cnt_q == '0) begin
          state_d = (off_q == '0) ? bspu_pkg::ST_IDLE : bspu_pkg::ST_MERGE;
        end
      end
      bspu_pkg::ST_MERGE: begin
        state_d = bspu_pkg::ST_IDLE;
      end
      default: state_d = bspu_pkg::ST_IDLE;
    endcase
  end

  // store control
  always_comb begin
    store_req = '0;
    wr_addr   = stream_addr;
    rd_addr   = stream_addr;
    unique case (state_q)
      bspu_pkg::ST_CLEAR: begin
        store_req.wr_en = 1'b1;
        wr_addr         = clr_q;
      end
      bspu_pkg::ST_RD: begin
        store_req.rd_en = 1'b1;
      end
      bspu_pkg::ST_WR: begin
        // a partly filled first byte needs its old contents
        if (cnt_q != '0 || off_q == '0) begin
          store_req.wr_en   = 1'b1;
          store_req.wr_data = shf_q[7:0];
        end else begin
          store_req.rd_en = 1'b1;
        end
      end
      bspu_pkg::ST_MERGE: begin
        store_req.wr_en   = 1'b1;
        store_req.wr_data = rd_data | shf_q[7:0];
      end
      default: begin
        store_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bspu_pkg::ST_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == bspu_pkg::ST_RD);
      rd_first_q <= (state_q == bspu_pkg::ST_RD) && (cnt_q == '0);
      done_q     <= 1'b0;
      unique case (state_q)
        bspu_pkg::ST_CLEAR: begin
          clr_q <= clr_q + SAW'(1);
        end
        bspu_pkg::ST_IDLE: begin
          if (accept) begin
            cnt_q  <= (mode_i == bspu_pkg::ModeWrite) ? span_end[6:3] : '0;
            done_q <= (n_sat == '0);
          end
        end
        bspu_pkg::ST_RD: begin
          cnt_q <= cnt_q + bspu_pkg::SpanW'(1);
        end
        bspu_pkg::ST_RDLAST: begin
          done_q <= 1'b1;
        end
        bspu_pkg::ST_WR: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - bspu_pkg::SpanW'(1);
          end else begin
            done_q <= (off_q == '0);
          end
        end
        bspu_pkg::ST_MERGE: begin
          done_q <= 1'b1;
        end
        default: begin
          cnt_q <= '0;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      addr0_q  <= bit_position_i[bspu_pkg::PosW-1:3];
      off_q    <= bit_position_i[2:0] & bspu_pkg::OffMask;
      tail_q   <= ~span_end[2:0];
      last_q   <= span_end[6:3];
      shf_q    <= frame;
      acc_q    <= '0;
      result_q <= '0;
    end else begin
      if (rd_vld_q) acc_q <= acc_next;
      // advance to the next lower byte, hold the first one for the merge
      if (state_q == bspu_pkg::ST_WR && cnt_q != '0) shf_q <= shf_q >> 8;
      if (state_q == bspu_pkg::ST_RDLAST) result_q <= acc_align[bspu_pkg::ValueW-1:0];
    end
  end

  assign done_o       = done_q;
  assign read_value_o = result_q;

  bspu_store #(
    .STORE_BYTES (STORE_BYTES),
    .ADDR_W      (SAW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  a_write_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_q == bspu_pkg::ModeWrite |-> read_value_o == '0)
    else $error("nonzero result after a write request");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && n_sat != '0 |=> busy)
    else $error("request with nonzero count did not raise busy");

  a_store_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> busy)
    else $error("store written while idle");

  a_span_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bspu_pkg::ST_RD || state_q == bspu_pkg::ST_WR)
      |-> cnt_q <= bspu_pkg::MaxByteIdx)
    else $error("byte index beyond nine bytes");

  a_read_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == bspu_pkg::ST_RD || state_q == bspu_pkg::ST_RDLAST))
    else $error("read data arrived outside a read");

endmodule
